[design/a85_pkg.sv]
// ----------------------------------------------------------------------------
// a85_pkg
// Shared types, codes and constants of the Ascii85 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package a85_pkg;

	localparam int GROUP_LEN = 5;
	localparam int DIGIT_W   = 7;
	localparam int CODE_W    = 32;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT_ON = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT    = 2'd2;

	localparam logic [1:0] FMT_STANDARD = 2'd0;
	localparam logic [1:0] FMT_BTOA_NEW = 2'd2;

	localparam logic OP_END = 1'b1;

	localparam logic [7:0] CH_FIRST = 8'h21;
	localparam logic [7:0] CH_LAST  = 8'h75;
	localparam logic [7:0] CH_ZERO  = 8'h7a;
	localparam logic [7:0] CH_SPACE = 8'h79;
	localparam logic [7:0] CH_END   = 8'h7e;

	localparam logic [DIGIT_W-1:0] PAD_DIGIT = 7'd84;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD,
		ST_CALC,
		ST_EMIT,
		ST_NULL
	} state_t;

	typedef enum logic [2:0] {
		CLS_IGNORE,
		CLS_END,
		CLS_DIGIT,
		CLS_ZERO,
		CLS_SPACE
	} char_cls_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] in_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic       end_of_data;
		logic       size_mismatch;
	} out_item_t;

	typedef struct packed {
		logic in_open;
		logic store_digit;
		logic calc_init;
		logic calc_step;
		logic emit_byte;
		logic emit_null;
		logic end_clear;
	} cmd_t;

	typedef struct packed {
		logic      in_fire;
		char_cls_t cls;
		logic      gc_zero;
		logic      gc_full;
		logic      rep_last;
		logic      calc_last;
		logic      emit_more;
		logic      emit_last;
		logic      out_free;
	} sts_t;

	// Digits of four spaces, used by the 'y' shorthand.
	function automatic logic [DIGIT_W-1:0] space_digit(input logic [CNT_W-1:0] k);
		logic [DIGIT_W-1:0] d;
		case (k)
			3'd0: d = 7'h0a;
			3'd1: d = 7'h1b;
			3'd2: d = 7'h35;
			3'd3: d = 7'h43;
			3'd4: d = 7'h2b;
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[design/a85_if.sv]
// ----------------------------------------------------------------------------
// a85_if
// Valid/ready channels carrying encoded characters in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface a85_in_if;
	logic               valid;
	logic               ready;
	a85_pkg::in_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface a85_out_if;
	logic               valid;
	logic               ready;
	a85_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/a85_ctrl.sv]
// ----------------------------------------------------------------------------
// a85_ctrl
// Sequencer that steps the datapath through digit stores, group conversion
// and byte delivery for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire a85_pkg::sts_t sts,
	output a85_pkg::cmd_t      cmd
);

	a85_pkg::state_t state_q;
	a85_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= a85_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			a85_pkg::ST_IDLE: begin
				if (sts.in_fire) state_d = a85_pkg::ST_DISPATCH;
			end
			a85_pkg::ST_DISPATCH: begin
				case (sts.cls)
					a85_pkg::CLS_IGNORE: state_d = a85_pkg::ST_IDLE;
					a85_pkg::CLS_END: begin
						state_d = sts.gc_zero ? a85_pkg::ST_NULL : a85_pkg::ST_CALC;
					end
					default: state_d = a85_pkg::ST_ADD;
				endcase
			end
			a85_pkg::ST_ADD: begin
				if (sts.gc_full) begin
					state_d = a85_pkg::ST_CALC;
				end else if (sts.rep_last) begin
					state_d = a85_pkg::ST_IDLE;
				end
			end
			a85_pkg::ST_CALC: begin
				if (sts.calc_last) state_d = a85_pkg::ST_EMIT;
			end
			a85_pkg::ST_EMIT: begin
				if (!sts.emit_more) begin
					state_d = (sts.cls == a85_pkg::CLS_END) ? a85_pkg::ST_NULL
						: a85_pkg::ST_ADD;
				end else if (sts.out_free && sts.emit_last) begin
					state_d = (sts.cls == a85_pkg::CLS_END) ? a85_pkg::ST_IDLE
						: a85_pkg::ST_ADD;
				end
			end
			a85_pkg::ST_NULL: begin
				if (sts.out_free) state_d = a85_pkg::ST_IDLE;
			end
			default: state_d = a85_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			a85_pkg::ST_IDLE: begin
				cmd.in_open = 1'b1;
			end
			a85_pkg::ST_DISPATCH: begin
				if (sts.cls == a85_pkg::CLS_END && !sts.gc_zero) cmd.calc_init = 1'b1;
			end
			a85_pkg::ST_ADD: begin
				if (sts.gc_full) begin
					cmd.calc_init = 1'b1;
				end else begin
					cmd.store_digit = 1'b1;
				end
			end
			a85_pkg::ST_CALC: begin
				cmd.calc_step = 1'b1;
			end
			a85_pkg::ST_EMIT: begin
				if (sts.emit_more && sts.out_free) begin
					cmd.emit_byte = 1'b1;
					cmd.end_clear = sts.emit_last && (sts.cls == a85_pkg::CLS_END);
				end
			end
			a85_pkg::ST_NULL: begin
				if (sts.out_free) begin
					cmd.emit_null = 1'b1;
					cmd.end_clear = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[design/a85_dp.sv]
// ----------------------------------------------------------------------------
// a85_dp
// Datapath: configuration registers, digit group, base-85 accumulator,
// byte counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module a85_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [a85_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [a85_pkg::CFG_W-1:0]         wr_data,
	input  wire a85_pkg::cmd_t                     cmd,
	output a85_pkg::sts_t                          sts,
	a85_in_if.sink                                 in_chan,
	a85_out_if.source                              out_chan
);

	logic [1:0]                        fmt_q;
	logic                              lim_on_q;
	logic [a85_pkg::CODE_W-1:0]        limit_q;

	a85_pkg::char_cls_t                cls_q;
	a85_pkg::char_cls_t                cls_d;
	logic [7:0]                        ch_q;
	logic [a85_pkg::CNT_W-1:0]         rep_q;
	logic [a85_pkg::DIGIT_W-1:0]       digits_q [a85_pkg::GROUP_LEN];
	logic [a85_pkg::CNT_W-1:0]         gc_q;
	logic [a85_pkg::CNT_W-1:0]         fcnt_q;
	logic [a85_pkg::CNT_W-1:0]         step_q;
	logic [a85_pkg::CNT_W-1:0]         bidx_q;
	logic [a85_pkg::CODE_W-1:0]        code_q;
	logic [a85_pkg::CODE_W-1:0]        bc_q;
	logic                              out_valid_q;
	a85_pkg::out_item_t                out_q;

	logic [a85_pkg::DIGIT_W-1:0]       digit_new;
	logic [a85_pkg::DIGIT_W-1:0]       calc_digit;
	logic [a85_pkg::CODE_W-1:0]        code_next;
	logic [a85_pkg::CODE_W-1:0]        bc_inc;
	logic                              lim_hit;
	logic                              lim_block;
	logic                              is_end;
	logic                              in_fire;
	logic                              out_free;

	assign in_chan.ready    = cmd.in_open;
	assign in_fire          = in_chan.valid && cmd.in_open;
	assign out_chan.valid   = out_valid_q;
	assign out_chan.payload = out_q;
	assign out_free         = !out_valid_q || out_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= '0;
			lim_on_q <= 1'b0;
			limit_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				a85_pkg::REG_FORMAT_MODE:   fmt_q    <= wr_data[1:0];
				a85_pkg::REG_SIZE_LIMIT_ON: lim_on_q <= wr_data[0];
				a85_pkg::REG_SIZE_LIMIT:    limit_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (in_chan.payload.operation == a85_pkg::OP_END
			|| (fmt_q == a85_pkg::FMT_STANDARD && in_chan.payload.in_char == a85_pkg::CH_END)) begin
			cls_d = a85_pkg::CLS_END;
		end else if (in_chan.payload.in_char inside {[a85_pkg::CH_FIRST:a85_pkg::CH_LAST]}) begin
			cls_d = a85_pkg::CLS_DIGIT;
		end else if (in_chan.payload.in_char == a85_pkg::CH_ZERO) begin
			cls_d = a85_pkg::CLS_ZERO;
		end else if (in_chan.payload.in_char == a85_pkg::CH_SPACE
			&& fmt_q == a85_pkg::FMT_BTOA_NEW) begin
			cls_d = a85_pkg::CLS_SPACE;
		end else begin
			cls_d = a85_pkg::CLS_IGNORE;
		end
	end

	always_comb begin
		case (cls_q)
			a85_pkg::CLS_DIGIT: digit_new = a85_pkg::DIGIT_W'(ch_q - a85_pkg::CH_FIRST);
			a85_pkg::CLS_SPACE: digit_new = a85_pkg::space_digit(rep_q);
			default:            digit_new = '0;
		endcase
	end

	assign calc_digit = (step_q < fcnt_q) ? digits_q[step_q] : a85_pkg::PAD_DIGIT;
	// Multiplication by 85 as 64 + 16 + 4 + 1, wrapping at 32 bits.
	assign code_next = (code_q << 6) + (code_q << 4) + (code_q << 2) + code_q
		+ a85_pkg::CODE_W'(calc_digit);

	assign bc_inc    = bc_q + 1'b1;
	assign lim_hit   = (bc_inc == limit_q);
	assign lim_block = lim_on_q && !(bc_q < limit_q);
	assign is_end    = (cls_q == a85_pkg::CLS_END);

	always_comb begin
		sts           = '0;
		sts.in_fire   = in_fire;
		sts.cls       = cls_q;
		sts.gc_zero   = (gc_q == '0);
		sts.gc_full   = (gc_q == a85_pkg::CNT_W'(a85_pkg::GROUP_LEN));
		sts.rep_last  = (cls_q == a85_pkg::CLS_DIGIT)
			|| (rep_q == a85_pkg::CNT_W'(a85_pkg::GROUP_LEN - 1));
		sts.calc_last = (step_q == a85_pkg::CNT_W'(a85_pkg::GROUP_LEN - 1));
		sts.emit_more = ((bidx_q + 3'd1) < fcnt_q) && !lim_block;
		sts.emit_last = ((bidx_q + 3'd2) == fcnt_q) || (lim_on_q && lim_hit);
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cls_q <= cls_d;
			ch_q  <= in_chan.payload.in_char;
		end
		if (cmd.store_digit) begin
			digits_q[gc_q] <= digit_new;
		end
		if (cmd.calc_init) begin
			code_q <= a85_pkg::CODE_W'(digits_q[0]);
			step_q <= 3'd1;
			fcnt_q <= gc_q;
			bidx_q <= '0;
		end else if (cmd.calc_step) begin
			code_q <= code_next;
			step_q <= step_q + 1'b1;
		end else if (cmd.emit_byte) begin
			code_q <= code_q << 8;
			bidx_q <= bidx_q + 1'b1;
		end
		if (cmd.emit_byte) begin
			out_q.data_byte     <= code_q[a85_pkg::CODE_W-1 -: 8];
			out_q.byte_valid    <= 1'b1;
			out_q.last_of_run   <= sts.emit_last;
			out_q.end_of_data   <= sts.emit_last && is_end;
			out_q.size_mismatch <= sts.emit_last && is_end && lim_on_q && !lim_hit;
		end else if (cmd.emit_null) begin
			out_q.data_byte     <= '0;
			out_q.byte_valid    <= 1'b0;
			out_q.last_of_run   <= 1'b1;
			out_q.end_of_data   <= 1'b1;
			out_q.size_mismatch <= lim_on_q && (bc_q != limit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q       <= '0;
			gc_q        <= '0;
			bc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				rep_q <= '0;
			end else if (cmd.store_digit) begin
				rep_q <= rep_q + 1'b1;
			end
			if (cmd.end_clear || cmd.calc_init) begin
				gc_q <= '0;
			end else if (cmd.store_digit) begin
				gc_q <= gc_q + 1'b1;
			end
			if (cmd.end_clear) begin
				bc_q <= '0;
			end else if (cmd.emit_byte) begin
				bc_q <= bc_inc;
			end
			if (cmd.emit_byte || cmd.emit_null) begin
				out_valid_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		gc_q <= a85_pkg::CNT_W'(a85_pkg::GROUP_LEN))
		else $error("digit group count above group length");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_byte && lim_on_q |-> bc_q < limit_q)
		else $error("byte emitted beyond the size limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.size_mismatch |-> out_q.end_of_data && out_q.last_of_run)
		else $error("size mismatch flagged outside an end result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.byte_valid |-> out_q.end_of_data)
		else $error("empty result that is not an end result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_byte || cmd.emit_null) |-> out_free)
		else $error("output register overwritten while still pending");

endmodule

`default_nettype wire

[design/ascii85_stream_decoder.sv]
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Ascii85 decoder taking one encoded character per request and delivering
// decoded bytes, with end-of-data and byte-limit reporting.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake     Contents
//   in_chan    in         valid/ready   operation, in_char
//   out_chan   out        valid/ready   data_byte, byte_valid, last_of_run,
//                                       end_of_data, size_mismatch
//   wr_*       in         wr_en only    wr_index, wr_data
//
// An ignored character returns to idle after dispatch; a digit is stored,
// and 'z' or 'y' stores five digits. A group conversion makes four passes
// through the shared multiply-by-85 accumulator, then sends one byte per
// cycle, when the output is free, through the single output register.
// Reset clears the sequencer, the group and byte counts; there is no
// clearing pass. A stalled output holds the sequencer in place while bytes
// are pending; a new request is taken only after the previous one finishes.
`default_nettype none

module ascii85_stream_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [a85_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [a85_pkg::CFG_W-1:0]     wr_data,
	a85_in_if.sink                             in_chan,
	a85_out_if.source                          out_chan
);

	a85_pkg::cmd_t cmd;
	a85_pkg::sts_t sts;

	a85_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	a85_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd),
		.sts      (sts),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

endmodule

`default_nettype wire

[tb/a85_decode_tracker_pkg.sv]
// ----------------------------------------------------------------------------
// a85_decode_tracker_pkg
// Predicts the decoded bytes and end reports of the Ascii85 stream decoder
// from the requests it accepts, and checks each delivered result against the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------

package a85_decode_tracker_pkg;

	import a85_pkg::*;

	// Digits that encode four spaces, packed first digit first.
	localparam logic [GROUP_LEN*DIGIT_W-1:0] FOUR_SPACES =
		{7'd10, 7'd27, 7'd53, 7'd67, 7'd43};

	class a85_decode_tracker;
		logic [1:0]         fmt;
		logic               lim_on;
		logic [31:0]        lim;
		logic [DIGIT_W-1:0] digits [GROUP_LEN];
		int unsigned        n_digits;
		logic [31:0]        n_bytes;
		logic [7:0]         new_bytes [$];
		out_item_t          pending_outputs [$];
		int unsigned        mismatches;

		function new();
			fmt = FMT_STANDARD;
			lim_on = 1'b0;
			lim = '0;
			foreach (digits[i]) digits[i] = '0;
			n_digits = 0;
			n_bytes = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_FORMAT_MODE: fmt = data[1:0];
				REG_SIZE_LIMIT_ON: lim_on = data[0];
				REG_SIZE_LIMIT: lim = data[31:0];
				default: ;
			endcase
		endfunction

		function int unsigned outstanding();
			return pending_outputs.size();
		endfunction

		// Short groups are padded with the top digit and give one byte less
		// than their digit count; the byte limit drops what lies beyond it.
		function void convert_group();
			logic [31:0] code;
			int unsigned i;
			if (n_digits == 0)
				return;
			code = 32'(digits[0]);
			for (i = 1; i < GROUP_LEN; i++)
				code = code * 32'd85 + ((i < n_digits) ? 32'(digits[i]) : 32'(PAD_DIGIT));
			for (i = 0; i < n_digits - 1 && i < 4; i++) begin
				if (lim_on && n_bytes >= lim)
					break;
				new_bytes.push_back(code[31-8*i -: 8]);
				n_bytes++;
			end
			n_digits = 0;
		endfunction

		function void add_digit(logic [DIGIT_W-1:0] d);
			if (n_digits >= GROUP_LEN)
				convert_group();
			digits[n_digits] = d;
			n_digits++;
		endfunction

		function void take_char(in_item_t req);
			logic      is_end;
			logic      off_count;
			out_item_t r;
			int        k;
			int        total;
			new_bytes.delete();
			off_count = 1'b0;
			is_end = (req.operation == OP_END) || (fmt == FMT_STANDARD && req.in_char == CH_END);
			if (is_end) begin
				convert_group();
				off_count = lim_on && (n_bytes != lim);
				n_digits = 0;
				n_bytes = '0;
			end else if (req.in_char >= CH_FIRST && req.in_char <= CH_LAST) begin
				add_digit(7'(req.in_char - CH_FIRST));
			end else if (req.in_char == CH_ZERO) begin
				for (k = 0; k < GROUP_LEN; k++)
					add_digit('0);
			end else if (req.in_char == CH_SPACE && fmt == FMT_BTOA_NEW) begin
				for (k = 0; k < GROUP_LEN; k++)
					add_digit(FOUR_SPACES[(GROUP_LEN-k)*DIGIT_W-1 -: DIGIT_W]);
			end
			total = new_bytes.size();
			if (is_end && total == 0)
				total = 1;
			for (k = 0; k < total; k++) begin
				r.data_byte = (k < new_bytes.size()) ? new_bytes[k] : 8'h00;
				r.byte_valid = (k < new_bytes.size());
				r.last_of_run = (k == total - 1);
				r.end_of_data = r.last_of_run && is_end;
				r.size_mismatch = r.end_of_data && off_count;
				pending_outputs.push_back(r);
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected: expected none, got %0h %0b%0b%0b%0b",
					$time, got.data_byte, got.byte_valid, got.last_of_run,
					got.end_of_data, got.size_mismatch);
				return;
			end
			want = pending_outputs.pop_front();
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("byte_valid", want.byte_valid, got.byte_valid);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
			compare_field("end_of_data", want.end_of_data, got.end_of_data);
			compare_field("size_mismatch", want.size_mismatch, got.size_mismatch);
		endfunction
	endclass

endpackage

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the Ascii85 stream decoder: directed streams over the character
// classes, format modes and byte limits, then random streams under random
// sender bursts and receiver stalls, all checked against a running prediction.
// ----------------------------------------------------------------------------

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import a85_pkg::*;
	import a85_decode_tracker_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int          RANDOM_ITEMS  = 420;
	localparam int          PHASES        = 6;
	localparam logic        OP_DATA       = 1'b0;

	typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_e;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	a85_in_if  in_chan ();
	a85_out_if out_chan ();

	a85_decode_tracker tracker = new();
	int unsigned       burst_left;

	ascii85_stream_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		rx_pattern_e pattern;
		int unsigned span;
		int unsigned tick;
		tick = 0;
		out_chan.ready <= 1'b0;
		forever begin
			pattern = rx_pattern_e'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(posedge clk);
				tick++;
				case (pattern)
					RX_OPEN: out_chan.ready <= 1'b1;
					RX_MOSTLY: out_chan.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: out_chan.ready <= ($urandom_range(0, 3) == 0);
					default: out_chan.ready <= ((tick % 7) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1)
			tracker.take_char(in_chan.payload);
		if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
			tracker.check_output(out_chan.payload);
	end

	task automatic send(input logic op, input logic [7:0] ch);
		if (burst_left == 0) begin
			in_chan.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
		end
		in_chan.valid <= 1'b1;
		in_chan.payload <= in_item_t'{operation: op, in_char: ch};
		do @(posedge clk); while (in_chan.ready !== 1'b1);
		burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(OP_DATA, s[i]);
	endtask

	task automatic settle();
		in_chan.valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] fmt, input logic lim_on, input logic [31:0] lim);
		logic [CFG_W-1:0] junk;
		junk = $urandom();
		wr_en <= 1'b1;
		wr_index <= REG_FORMAT_MODE;
		wr_data <= {junk[CFG_W-1:2], fmt};
		tracker.write_reg(REG_FORMAT_MODE, {junk[CFG_W-1:2], fmt});
		@(posedge clk);
		wr_index <= REG_SIZE_LIMIT_ON;
		wr_data <= {junk[CFG_W-1:1], lim_on};
		tracker.write_reg(REG_SIZE_LIMIT_ON, {junk[CFG_W-1:1], lim_on});
		@(posedge clk);
		wr_index <= REG_SIZE_LIMIT;
		wr_data <= lim;
		tracker.write_reg(REG_SIZE_LIMIT, lim);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] random_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 72)
			return CH_FIRST + 8'($urandom_range(0, 84));
		else if (r < 80)
			return CH_ZERO;
		else if (r < 86)
			return CH_SPACE;
		else if (r < 90)
			return CH_END;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [1:0]  fmt;
		logic        lim_on;
		logic [31:0] lim;
		logic        op;
		logic [7:0]  ch;
		int          taken;
		int          run_len;
		bit          paused;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		in_chan.valid <= 1'b0;
		in_chan.payload <= '0;
		burst_left = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(FMT_STANDARD, 1'b0, 32'd0);
		send_text("uuuuu");
		send_text("z");
		send(OP_DATA, CH_END);
		send_text("!");
		send(OP_END, 8'hff);
		send(OP_DATA, 8'h00);
		send(OP_DATA, 8'hff);
		send(OP_DATA, 8'h76);
		send(OP_DATA, CH_SPACE);
		send_text("s8");
		send(OP_END, CH_ZERO);
		settle();

		// A limit that stops inside the last group leaves the count on target.
		configure(FMT_BTOA_NEW, 1'b1, 32'd5);
		send(OP_DATA, CH_SPACE);
		send(OP_DATA, CH_SPACE);
		send(OP_DATA, CH_END);
		send(OP_END, 8'h00);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			fmt = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			lim_on = (phase < 2) ? 1'b1 : 1'($urandom_range(0, 1));
			case ((phase < 2) ? phase : $urandom_range(0, 3))
				0: lim = 32'd0;
				1: lim = 32'hffff_ffff;
				2: lim = 32'($urandom_range(1, 24));
				default: lim = $urandom();
			endcase
			configure(fmt, lim_on, lim);
			taken = 0;
			while (taken < RANDOM_ITEMS / PHASES) begin
				run_len = $urandom_range(0, 24);
				for (int i = 0; i <= run_len; i++) begin
					if (i == run_len) begin
						op = ($urandom_range(0, 9) < 7) ? OP_END : OP_DATA;
						ch = (op == OP_END) ? 8'($urandom_range(0, 255)) : CH_END;
					end else begin
						op = OP_DATA;
						ch = random_char();
					end
					send(op, ch);
					taken++;
					if (!paused && phase == 2 && taken >= RANDOM_ITEMS / PHASES / 2) begin
						paused = 1'b1;
						settle();
					end
				end
			end
		end

		settle();
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
